// ===== hdl/sekf_pkg.sv =====
// sekf_pkg: shared types, constants and helpers for the scalar yaw estimator
// no dependencies
package sekf_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CSTEPS = (CORDIC_STEPS < 31) ? CORDIC_STEPS : 31;
    localparam int CW = $clog2(CSTEPS + 1);

    localparam logic signed [31:0] ONE_Q = 32'sd65536;
    localparam logic signed [31:0] TWO_PI_Q = 32'sd411775;
    localparam logic signed [31:0] PI_Q = 32'sd205887;
    localparam logic signed [31:0] HALF_PI_Q = 32'sd102944;
    localparam logic signed [31:0] CORDIC_GAIN_Q = 32'sd39798;
    localparam logic signed [31:0] DEG_PER_RAD_Q = 32'sd3754936;
    localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_STATE = 2'd1;
    localparam logic [1:0] FUNC_MEAS = 2'd2;

    localparam logic [2:0] ST_LATCHED = 3'd0;
    localparam logic [2:0] ST_INIT = 3'd1;
    localparam logic [2:0] ST_NONE = 3'd2;
    localparam logic [2:0] ST_PRED = 3'd3;
    localparam logic [2:0] ST_CORR = 3'd4;

    localparam logic [2:0] REG_STEP = 3'd0;
    localparam logic [2:0] REG_HITCH = 3'd1;
    localparam logic [2:0] REG_TRAILER = 3'd2;
    localparam logic [2:0] REG_INITVAR = 3'd3;
    localparam logic [2:0] REG_QNOISE = 3'd4;
    localparam logic [2:0] REG_RNOISE = 3'd5;
    localparam logic [2:0] REG_GAIN = 3'd6;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] linear_velocity;
        logic signed [31:0] angular_velocity;
        logic signed [31:0] measured_yaw;
    } item_t;

    typedef struct packed {
        logic [16:0] step_time;
        logic [30:0] hitch_length;
        logic [30:0] trailer_length;
        logic [30:0] initial_variance;
        logic [30:0] process_noise;
        logic [30:0] measurement_noise;
        logic signed [31:0] measurement_gain;
    } cfg_t;

    function automatic logic signed [31:0] atan_lut(input logic [4:0] i);
        logic signed [31:0] r;
        begin
            unique case (i)
                5'd0: r = 32'sd51472;
                5'd1: r = 32'sd30385;
                5'd2: r = 32'sd16055;
                5'd3: r = 32'sd8150;
                5'd4: r = 32'sd4091;
                5'd5: r = 32'sd2047;
                5'd6: r = 32'sd1024;
                5'd7: r = 32'sd512;
                5'd8: r = 32'sd256;
                5'd9: r = 32'sd128;
                5'd10: r = 32'sd64;
                5'd11: r = 32'sd32;
                5'd12: r = 32'sd16;
                5'd13: r = 32'sd8;
                5'd14: r = 32'sd4;
                5'd15: r = 32'sd2;
                5'd16: r = 32'sd1;
                default: r = 32'sd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        begin
            if (v > 34'sh07fffffff)
                r = S32_MAX;
            else if (v < -34'sh080000000)
                r = S32_MIN;
            else
                r = v[31:0];
            return r;
        end
    endfunction

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        logic signed [31:0] r;
        begin
            if (v > 64'sh000000007fffffff)
                r = S32_MAX;
            else if (v < -64'sh0000000080000000)
                r = S32_MIN;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage

// ===== hdl/sekf_front.sv =====
// sekf_front: accepts event items of every kind and queues them, two deep,
// for the back end, which latches state and measurements; uses sekf_pkg
module sekf_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  sekf_pkg::item_t    in_item,
    output logic               q_valid,
    input  logic               q_take,
    output sekf_pkg::item_t    q_item
);
    import sekf_pkg::*;

    item_t q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic rd_reg, wr_reg;
    logic push, pop;

    assign in_stall = (cnt_reg == 2'd2);
    assign push = in_valid && !in_stall;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_take;
    assign q_item = q_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= in_item;
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !pop) |=> cnt_reg == 2'd2)
        else $error("full queue lost an item");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 && push) |=> q_valid)
        else $error("pushed item not visible");
endmodule

// ===== hdl/sekf_back.sv =====
// sekf_back: sequencer with a shared multiplier, serial divider and CORDIC
// that carries out each queued event; uses sekf_pkg
module sekf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_take,
    input  sekf_pkg::item_t    q_item,
    input  sekf_pkg::cfg_t     cfg,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic signed [31:0] predicted_yaw,
    output logic signed [31:0] predicted_degrees,
    output logic signed [31:0] estimated_yaw,
    output logic signed [31:0] estimated_degrees
);
    import sekf_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MUL = 3'd2;
    localparam logic [2:0] S_DIV = 3'd3;
    localparam logic [2:0] S_COR = 3'd4;
    localparam logic [2:0] S_OUT = 3'd5;
    localparam logic [2:0] S_RED = 3'd6;

    // micro program step codes
    localparam logic [5:0] P_CS0 = 6'd0;

    // two pi scaled to the top quotient bit of the angle reduction
    localparam logic [31:0] RED_TOP = 32'(TWO_PI_Q) << 12;
    localparam logic [3:0] RED_STEPS = 4'd13;

    logic [2:0] st_reg, st_next;
    logic [5:0] pc_reg;

    logic ready_reg, spend_reg, mpend_reg;
    logic signed [31:0] hmeas_reg, yaw_now_reg, yaw_bef_reg;
    logic signed [31:0] spd_now_reg, tr_now_reg, spd_bef_reg, tr_bef_reg, var_reg;

    logic signed [31:0] r_reg [16];
    logic signed [31:0] ma_reg, mb_reg;
    logic [3:0] dst_reg;

    logic signed [31:0] da_reg, db_reg;
    logic [63:0] dnum_reg, drem_reg;
    logic [31:0] dden_reg;
    logic [6:0] dcnt_reg;
    logic dneg_reg;

    logic signed [33:0] cx_reg, cy_reg, cr_reg;
    logic [CW-1:0] ccnt_reg;
    logic cneg_reg;

    logic [31:0] rmag_reg, rsub_reg;
    logic [3:0] rcnt_reg;
    logic rneg_reg;

    logic [2:0] ost_reg;
    logic ovalid_reg;

    logic signed [63:0] prod;
    logic signed [31:0] mul_q;
    logic signed [63:0] prod_sh;

    assign prod = ma_reg * mb_reg;
    assign prod_sh = prod >>> 16;
    assign mul_q = sat64(prod_sh);

    function automatic logic signed [31:0] addq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat34({{2{a[31]}}, a} + {{2{b[31]}}, b});
    endfunction

    function automatic logic signed [31:0] subq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat34({{2{a[31]}}, a} - {{2{b[31]}}, b});
    endfunction

    logic signed [31:0] l1, l2;
    assign l1 = {1'b0, cfg.hitch_length};
    assign l2 = {1'b0, cfg.trailer_length};

    assign q_take = (st_reg == S_IDLE) && !ovalid_reg;
    assign out_valid = ovalid_reg;
    assign status = ost_reg;

    // register file slots
    localparam logic [3:0] R_S = 4'd0, R_C = 4'd1, R_T1 = 4'd2, R_T2 = 4'd3;
    localparam logic [3:0] R_D1 = 4'd4, R_D2 = 4'd5, R_F = 4'd6, R_PRED = 4'd7;
    localparam logic [3:0] R_PG = 4'd8, R_K = 4'd9, R_V = 4'd10, R_X = 4'd11;
    localparam logic [3:0] R_EST = 4'd12, R_Q = 4'd13, R_DEN = 4'd14, R_Y = 4'd15;

    logic signed [31:0] cord_in;

    always_comb
    begin
        priority if (pc_reg == 6'd12)
            cord_in = yaw_now_reg;
        else
            cord_in = yaw_bef_reg;
    end

    // angle reduction result from the serial remainder
    logic signed [31:0] red, red_pos;
    always_comb
    begin
        if (rneg_reg && rmag_reg != 32'd0)
            red_pos = TWO_PI_Q - $signed(rmag_reg);
        else
            red_pos = $signed(rmag_reg);
        if (red_pos > PI_Q)
            red = red_pos - TWO_PI_Q;
        else
            red = red_pos;
    end

    logic signed [33:0] cx_sh, cy_sh;
    assign cx_sh = cx_reg >>> ccnt_reg;
    assign cy_sh = cy_reg >>> ccnt_reg;

    logic [63:0] dtrial;
    assign dtrial = {drem_reg[62:0], dnum_reg[63]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            pc_reg <= P_CS0;
            ready_reg <= 1'b0;
            spend_reg <= 1'b0;
            mpend_reg <= 1'b0;
            hmeas_reg <= '0;
            yaw_now_reg <= '0;
            yaw_bef_reg <= '0;
            spd_now_reg <= '0;
            tr_now_reg <= '0;
            spd_bef_reg <= '0;
            tr_bef_reg <= '0;
            var_reg <= '0;
            ovalid_reg <= 1'b0;
            ost_reg <= ST_LATCHED;
        end
        else
        begin
            if (ovalid_reg && !out_stall)
                ovalid_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                begin
                    if (q_valid && !ovalid_reg)
                    begin
                        predicted_yaw <= '0;
                        predicted_degrees <= '0;
                        estimated_yaw <= '0;
                        estimated_degrees <= '0;
                        ost_reg <= ST_LATCHED;
                        unique case (q_item.func)
                            FUNC_STATE:
                            begin
                                spd_now_reg <= q_item.linear_velocity;
                                tr_now_reg <= q_item.angular_velocity;
                                spend_reg <= 1'b1;
                                ovalid_reg <= 1'b1;
                            end
                            FUNC_MEAS:
                            begin
                                hmeas_reg <= q_item.measured_yaw;
                                mpend_reg <= 1'b1;
                                ovalid_reg <= 1'b1;
                            end
                            FUNC_TICK:
                            begin
                                if (!ready_reg)
                                begin
                                    if (mpend_reg)
                                    begin
                                        yaw_now_reg <= hmeas_reg;
                                        yaw_bef_reg <= hmeas_reg;
                                        mpend_reg <= 1'b0;
                                        var_reg <= {1'b0, cfg.initial_variance};
                                        ready_reg <= 1'b1;
                                        ost_reg <= ST_INIT;
                                    end
                                    else
                                        ost_reg <= ST_NONE;
                                    ovalid_reg <= 1'b1;
                                end
                                else if (!spend_reg)
                                begin
                                    ost_reg <= ST_NONE;
                                    ovalid_reg <= 1'b1;
                                end
                                else
                                begin
                                    pc_reg <= P_CS0;
                                    st_reg <= S_EXEC;
                                end
                            end
                            default: ovalid_reg <= 1'b1;
                        endcase
                    end
                end
                S_MUL:
                begin
                    r_reg[dst_reg] <= mul_q;
                    st_reg <= S_EXEC;
                end
                S_DIV:
                begin
                    if (dcnt_reg != 7'd0)
                    begin
                        if (dtrial >= {32'd0, dden_reg})
                            drem_reg <= dtrial - {32'd0, dden_reg};
                        else
                            drem_reg <= dtrial;
                        dnum_reg <= {dnum_reg[62:0],
                                     (dtrial >= {32'd0, dden_reg})};
                        dcnt_reg <= dcnt_reg - 7'd1;
                    end
                    else
                    begin
                        if (db_reg == 0)
                            r_reg[dst_reg] <= (da_reg == 0) ? 32'sd0 :
                                ((da_reg > 0) ? S32_MAX : S32_MIN);
                        else if (dneg_reg)
                            r_reg[dst_reg] <= sat64(-$signed(dnum_reg));
                        else if (dnum_reg > 64'h7fffffff)
                            r_reg[dst_reg] <= S32_MAX;
                        else
                            r_reg[dst_reg] <= dnum_reg[31:0];
                        st_reg <= S_EXEC;
                    end
                end
                S_RED:
                begin
                    if (rcnt_reg != 4'd0)
                    begin
                        if (rmag_reg >= rsub_reg)
                            rmag_reg <= rmag_reg - rsub_reg;
                        rsub_reg <= rsub_reg >> 1;
                        rcnt_reg <= rcnt_reg - 4'd1;
                    end
                    else
                    begin
                        cx_reg <= 34'(CORDIC_GAIN_Q);
                        cy_reg <= '0;
                        ccnt_reg <= '0;
                        if (red > HALF_PI_Q)
                        begin
                            cr_reg <= 34'(PI_Q - red);
                            cneg_reg <= 1'b1;
                        end
                        else if (red < -HALF_PI_Q)
                        begin
                            cr_reg <= 34'(-PI_Q - red);
                            cneg_reg <= 1'b1;
                        end
                        else
                        begin
                            cr_reg <= 34'(red);
                            cneg_reg <= 1'b0;
                        end
                        st_reg <= S_COR;
                    end
                end
                S_COR:
                begin
                    if (ccnt_reg != CW'(CSTEPS))
                    begin
                        if (cr_reg >= 0)
                        begin
                            cx_reg <= cx_reg - cy_sh;
                            cy_reg <= cy_reg + cx_sh;
                            cr_reg <= cr_reg - 34'(atan_lut(5'(ccnt_reg)));
                        end
                        else
                        begin
                            cx_reg <= cx_reg + cy_sh;
                            cy_reg <= cy_reg - cx_sh;
                            cr_reg <= cr_reg + 34'(atan_lut(5'(ccnt_reg)));
                        end
                        ccnt_reg <= ccnt_reg + CW'(1);
                    end
                    else
                    begin
                        r_reg[R_S] <= sat34(cy_reg);
                        r_reg[R_C] <= sat34(cneg_reg ? -cx_reg : cx_reg);
                        pc_reg <= pc_reg + 6'd1;
                        st_reg <= S_EXEC;
                    end
                end
                S_OUT:
                begin
                    estimated_degrees <= mul_q;
                    ovalid_reg <= 1'b1;
                    st_reg <= S_IDLE;
                end
                S_EXEC:
                begin
                    // micro program: most steps issue one unit operation, the rest update registers directly
                    unique case (pc_reg)
                        6'd0, 6'd12, 6'd24:
                        begin
                            rmag_reg <= cord_in[31] ? 32'(-cord_in) : 32'(cord_in);
                            rneg_reg <= cord_in[31];
                            rsub_reg <= RED_TOP;
                            rcnt_reg <= RED_STEPS;
                            st_reg <= S_RED;
                        end
                        default:
                        begin
                            pc_reg <= pc_reg + 6'd1;
                        end
                    endcase
                    // second-level dispatch of arithmetic steps
                    unique case (pc_reg)
                        // yaw_rate(before): uses sincos(yaw_before)
                        6'd1: begin da_reg <= spd_bef_reg; db_reg <= l2; end
                        6'd2: begin ma_reg <= tr_bef_reg; mb_reg <= l1; end
                        6'd3: begin ma_reg <= r_reg[R_Q]; mb_reg <= r_reg[R_S]; end
                        6'd4: begin da_reg <= r_reg[R_X]; db_reg <= l2; end
                        6'd5: begin ma_reg <= r_reg[R_Q]; mb_reg <= r_reg[R_C]; end
                        6'd6: r_reg[R_D1] <= subq(subq(subq(32'sd0, r_reg[R_T1]),
                                                       r_reg[R_T2]), tr_bef_reg);
                        6'd13: begin da_reg <= spd_now_reg; db_reg <= l2; end
                        6'd14: begin ma_reg <= tr_now_reg; mb_reg <= l1; end
                        6'd15: begin ma_reg <= r_reg[R_Q]; mb_reg <= r_reg[R_S]; end
                        6'd16: begin da_reg <= r_reg[R_X]; db_reg <= l2; end
                        6'd17: begin ma_reg <= r_reg[R_Q]; mb_reg <= r_reg[R_C]; end
                        6'd18: r_reg[R_D2] <= subq(subq(subq(32'sd0, r_reg[R_T1]),
                                                        r_reg[R_T2]), tr_now_reg);
                        default: ;
                    endcase
                    unique case (pc_reg)
                        6'd1, 6'd13: begin dst_reg <= R_Q; st_reg <= S_DIV; end
                        6'd2, 6'd14: begin dst_reg <= R_X; st_reg <= S_MUL; end
                        6'd3, 6'd15: begin dst_reg <= R_T1; st_reg <= S_MUL; end
                        6'd4, 6'd16: begin dst_reg <= R_Q; st_reg <= S_DIV; end
                        6'd5, 6'd17: begin dst_reg <= R_T2; st_reg <= S_MUL; end
                        default: ;
                    endcase
                    if (pc_reg == 6'd6)
                        pc_reg <= 6'd12;
                    if (pc_reg == 6'd18)
                        pc_reg <= 6'd19;
                    // prediction, variance propagation, measurement correction and output
                    unique case (pc_reg)
                        6'd19:
                        begin
                            ma_reg <= sat34($signed({{2{r_reg[R_D1][31]}}, r_reg[R_D1]} +
                                             {{2{r_reg[R_D2][31]}}, r_reg[R_D2]}) >>> 1);
                            mb_reg <= {15'd0, cfg.step_time};
                            dst_reg <= R_T1;
                            st_reg <= S_MUL;
                        end
                        6'd20:
                        begin
                            r_reg[R_PRED] <= addq(yaw_bef_reg, r_reg[R_T1]);
                            pc_reg <= 6'd24;
                        end
                        6'd25:
                        begin
                            da_reg <= spd_bef_reg; db_reg <= l1;
                            dst_reg <= R_Q; st_reg <= S_DIV;
                        end
                        6'd26:
                        begin
                            ma_reg <= r_reg[R_Q]; mb_reg <= r_reg[R_C];
                            dst_reg <= R_T1; st_reg <= S_MUL;
                        end
                        6'd27:
                        begin
                            r_reg[R_F] <= subq(ONE_Q, r_reg[R_T1]);
                            ma_reg <= tr_bef_reg; mb_reg <= l1;
                            dst_reg <= R_X; st_reg <= S_MUL;
                        end
                        6'd28:
                        begin
                            da_reg <= r_reg[R_X]; db_reg <= l2;
                            dst_reg <= R_Q; st_reg <= S_DIV;
                        end
                        6'd29:
                        begin
                            ma_reg <= r_reg[R_Q]; mb_reg <= r_reg[R_S];
                            dst_reg <= R_T2; st_reg <= S_MUL;
                        end
                        6'd30:
                        begin
                            r_reg[R_F] <= addq(r_reg[R_F], r_reg[R_T2]);
                            ma_reg <= addq(r_reg[R_F], r_reg[R_T2]); mb_reg <= var_reg;
                            dst_reg <= R_V; st_reg <= S_MUL;
                        end
                        6'd31:
                        begin
                            ma_reg <= r_reg[R_V]; mb_reg <= r_reg[R_F];
                            dst_reg <= R_V; st_reg <= S_MUL;
                        end
                        6'd32:
                        begin
                            r_reg[R_V] <= addq(r_reg[R_V], {1'b0, cfg.process_noise});
                            spd_bef_reg <= spd_now_reg;
                            tr_bef_reg <= tr_now_reg;
                            spend_reg <= 1'b0;
                            if (!mpend_reg)
                            begin
                                var_reg <= addq(r_reg[R_V], {1'b0, cfg.process_noise});
                                r_reg[R_EST] <= r_reg[R_PRED];
                                ost_reg <= ST_PRED;
                                pc_reg <= 6'd44;
                            end
                        end
                        6'd33:
                        begin
                            ma_reg <= r_reg[R_V]; mb_reg <= cfg.measurement_gain;
                            dst_reg <= R_PG; st_reg <= S_MUL;
                        end
                        6'd34:
                        begin
                            ma_reg <= r_reg[R_PG]; mb_reg <= cfg.measurement_gain;
                            dst_reg <= R_DEN; st_reg <= S_MUL;
                        end
                        6'd35:
                        begin
                            da_reg <= r_reg[R_PG];
                            db_reg <= addq(r_reg[R_DEN], {1'b0, cfg.measurement_noise});
                            dst_reg <= R_K; st_reg <= S_DIV;
                        end
                        6'd36:
                        begin
                            ma_reg <= r_reg[R_K]; mb_reg <= cfg.measurement_gain;
                            dst_reg <= R_T1; st_reg <= S_MUL;
                        end
                        6'd37:
                        begin
                            ma_reg <= subq(ONE_Q, r_reg[R_T1]); mb_reg <= r_reg[R_V];
                            dst_reg <= R_V; st_reg <= S_MUL;
                        end
                        6'd38:
                        begin
                            var_reg <= r_reg[R_V];
                            ma_reg <= cfg.measurement_gain; mb_reg <= r_reg[R_PRED];
                            dst_reg <= R_T1; st_reg <= S_MUL;
                        end
                        6'd39:
                        begin
                            ma_reg <= subq(hmeas_reg, r_reg[R_T1]); mb_reg <= r_reg[R_K];
                            dst_reg <= R_T2; st_reg <= S_MUL;
                        end
                        6'd40:
                        begin
                            r_reg[R_EST] <= addq(r_reg[R_PRED], r_reg[R_T2]);
                            mpend_reg <= 1'b0;
                            ost_reg <= ST_CORR;
                            pc_reg <= 6'd44;
                        end
                        6'd44:
                        begin
                            yaw_bef_reg <= yaw_now_reg;
                            yaw_now_reg <= r_reg[R_EST];
                            predicted_yaw <= r_reg[R_PRED];
                            estimated_yaw <= r_reg[R_EST];
                            ma_reg <= r_reg[R_PRED]; mb_reg <= DEG_PER_RAD_Q;
                            dst_reg <= R_Y; st_reg <= S_MUL;
                        end
                        6'd45:
                        begin
                            predicted_degrees <= r_reg[R_Y];
                            ma_reg <= r_reg[R_EST]; mb_reg <= DEG_PER_RAD_Q;
                            st_reg <= S_OUT;
                        end
                        default: ;
                    endcase
                    if (pc_reg == 6'd7 || pc_reg == 6'd21 || pc_reg == 6'd41)
                        st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
            // divider launch: set up magnitudes when a divide is issued
            if (st_reg == S_EXEC && (pc_reg == 6'd1 || pc_reg == 6'd13 ||
                pc_reg == 6'd4 || pc_reg == 6'd16 || pc_reg == 6'd25 ||
                pc_reg == 6'd28 || pc_reg == 6'd35))
                dcnt_reg <= 7'd65;
            if (st_reg == S_DIV && dcnt_reg == 7'd65)
            begin
                dnum_reg <= {16'd0, (da_reg[31] ? 32'(-da_reg) : 32'(da_reg)), 16'd0};
                dden_reg <= db_reg[31] ? 32'(-db_reg) : 32'(db_reg);
                drem_reg <= '0;
                dneg_reg <= da_reg[31] ^ db_reg[31];
                dcnt_reg <= 7'd64;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> !out_valid)
        else $error("item taken with result pending");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_PRED || status == ST_CORR)) |-> ready_reg)
        else $error("filter result before initialization");
endmodule

// ===== hdl/sekf_cfg.sv =====
// sekf_cfg: configuration register bank with reset values
// uses sekf_pkg
module sekf_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output sekf_pkg::cfg_t    cfg
);
    import sekf_pkg::*;

    cfg_t cfg_reg;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_time <= 17'd2184;
            cfg_reg.hitch_length <= 31'd65536;
            cfg_reg.trailer_length <= 31'd65536;
            cfg_reg.initial_variance <= 31'd65536;
            cfg_reg.process_noise <= 31'd655;
            cfg_reg.measurement_noise <= 31'd6554;
            cfg_reg.measurement_gain <= 32'sd65536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STEP: cfg_reg.step_time <= cfg_data[16:0];
                REG_HITCH: cfg_reg.hitch_length <= cfg_data[30:0];
                REG_TRAILER: cfg_reg.trailer_length <= cfg_data[30:0];
                REG_INITVAR: cfg_reg.initial_variance <= cfg_data[30:0];
                REG_QNOISE: cfg_reg.process_noise <= cfg_data[30:0];
                REG_RNOISE: cfg_reg.measurement_noise <= cfg_data[30:0];
                REG_GAIN: cfg_reg.measurement_gain <= cfg_data;
                default: ;
            endcase
        end
    end
endmodule

// ===== hdl/scalar_ekf_yaw_estimator.sv =====
// scalar_ekf_yaw_estimator: top level of the one-state yaw Kalman filter
// sequencing: latch events and untimed ticks finish straight from idle; a full tick
// runs six serial divides, seven with a correction, and three CORDIC passes
// of 13 reduction and 16 rotation steps
// throughput: one item at a time in the back end, two items queue in front
// reset: asynchronous active low, clears filter state and loads register defaults
module scalar_ekf_yaw_estimator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  logic signed [31:0] linear_velocity,
    input  logic signed [31:0] angular_velocity,
    input  logic signed [31:0] measured_yaw,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic signed [31:0] predicted_yaw,
    output logic signed [31:0] predicted_degrees,
    output logic signed [31:0] estimated_yaw,
    output logic signed [31:0] estimated_degrees,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import sekf_pkg::*;

    item_t in_item, q_item;
    cfg_t cfg;
    logic q_valid, q_take;

    assign in_item.func = func;
    assign in_item.linear_velocity = linear_velocity;
    assign in_item.angular_velocity = angular_velocity;
    assign in_item.measured_yaw = measured_yaw;

    sekf_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cfg(cfg)
    );

    sekf_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_item(in_item), .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
    );

    sekf_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take),
        .q_item(q_item), .cfg(cfg), .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .predicted_yaw(predicted_yaw),
        .predicted_degrees(predicted_degrees), .estimated_yaw(estimated_yaw),
        .estimated_degrees(estimated_degrees)
    );
endmodule
